/* hw/rtl/mwf_pkg.sv */
// Package with the shared types, constants and helpers of the mutex with FIFO waiters.
package mwf_pkg;

    localparam int unsigned QDEPTH = 64;
    localparam int unsigned PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);
    localparam int unsigned ID_W   = 8;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [ID_W-1:0]  t_id;

    typedef enum logic {
        ACT_ACQUIRE = 1'b0,
        ACT_RELEASE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_GRANTED     = 2'd0,
        ST_QUEUED      = 2'd1,
        ST_ALREADY_OWN = 2'd2,
        ST_QUEUE_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic action;
        t_id  task_id;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic       block_task;
        logic       wake_valid;
        t_id        wake_task_id;
        logic       owner_valid;
        t_id        owner_id;
    } t_rsp;

    function automatic t_ptr next_slot(input t_ptr p);
        next_slot = (p == t_ptr'(QDEPTH - 1)) ? '0 : p + t_ptr'(1);
    endfunction

endpackage

/* hw/rtl/mwf_channels.sv */
// Handshake channel interfaces for requests and responses.
interface mwf_req_if;
    import mwf_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mwf_rsp_if;
    import mwf_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/mwf_queue.sv */
// Waiter queue: a memory with a head register and a prefetched second entry.
module mwf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mwf_pkg::t_id    i_push_data,
    input  logic            i_pop,
    output mwf_pkg::t_id    o_head,
    output mwf_pkg::t_cnt   o_count
);
    import mwf_pkg::*;

    t_id  mem [QDEPTH];
    t_ptr r_wr_ptr, n_wr_ptr;
    t_ptr r_rd_ptr, n_rd_ptr;
    t_cnt r_count, n_count;
    t_id  r_head, n_head;
    t_id  r_mem_q;
    logic r_fwd_hit;
    t_id  r_fwd_data;
    t_id  second;
    t_ptr rd_addr;

    // The entry behind the head was read last cycle, or written in that same cycle.
    assign second  = r_fwd_hit ? r_fwd_data : r_mem_q;
    assign rd_addr = next_slot(n_rd_ptr);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        n_head   = r_head;
        if (i_push) begin
            n_wr_ptr = next_slot(r_wr_ptr);
            n_count  = r_count + t_cnt'(1);
            if (r_count == '0) begin
                n_head = i_push_data;
            end
        end else if (i_pop) begin
            n_rd_ptr = next_slot(r_rd_ptr);
            n_count  = r_count - t_cnt'(1);
            n_head   = second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr_ptr] <= i_push_data;
        end
        r_mem_q    <= mem[rd_addr];
        r_fwd_hit  <= i_push && (r_wr_ptr == rd_addr);
        r_fwd_data <= i_push_data;
        r_head     <= n_head;
    end

    assign o_head  = r_head;
    assign o_count = r_count;

endmodule

/* hw/rtl/mutex_with_fifo_waiters.sv */
// Top level of the mutex with a first-in first-out queue of waiting tasks.
// An accepted request is held in the request register, and its response then in the output register.
// Throughput: one request per cycle while responses are taken; the owner, flag and queue pointers update in one step.
// A stalled response holds the decision stage, and the request register stalls behind it.
// Reset is synchronous and active low; it unlocks the mutex and empties the queue.
module mutex_with_fifo_waiters (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mwf_req_if.sink   i_req,
    mwf_rsp_if.source o_rsp
);
    import mwf_pkg::*;

    logic r_req_valid;
    t_req r_req;
    logic r_rsp_valid;
    t_rsp r_rsp, n_rsp;
    logic r_locked, n_locked;
    t_id  r_owner, n_owner;
    logic adv;
    logic push, pop;
    t_id  head;
    t_cnt count;

    assign adv         = r_req_valid && (!r_rsp_valid || o_rsp.ready);
    assign i_req.ready = !r_req_valid || adv;

    mwf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (r_req.task_id),
        .i_pop       (pop),
        .o_head      (head),
        .o_count     (count)
    );

    always_comb begin
        push     = 1'b0;
        pop      = 1'b0;
        n_locked = r_locked;
        n_owner  = r_owner;
        n_rsp    = '0;
        if (r_req.action == ACT_ACQUIRE) begin
            priority if (!r_locked) begin
                n_locked     = 1'b1;
                n_owner      = r_req.task_id;
                n_rsp.status = ST_GRANTED;
            end else if (r_owner == r_req.task_id) begin
                n_rsp.status = ST_ALREADY_OWN;
            end else if (count == t_cnt'(QDEPTH)) begin
                n_rsp.status = ST_QUEUE_FULL;
            end else begin
                push             = 1'b1;
                n_rsp.status     = ST_QUEUED;
                n_rsp.block_task = 1'b1;
            end
        end else if (r_locked) begin
            if (count != '0) begin
                pop                = 1'b1;
                n_owner            = head;
                n_rsp.wake_valid   = 1'b1;
                n_rsp.wake_task_id = head;
            end else begin
                n_locked = 1'b0;
                n_owner  = '0;
            end
        end
        n_rsp.owner_valid = n_locked;
        n_rsp.owner_id    = n_locked ? n_owner : '0;
        if (!adv) begin
            push     = 1'b0;
            pop      = 1'b0;
            n_locked = r_locked;
            n_owner  = r_owner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_locked    <= 1'b0;
            r_owner     <= '0;
        end else begin
            if (i_req.ready) begin
                r_req_valid <= i_req.valid;
            end
            if (adv) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            r_locked <= n_locked;
            r_owner  <= n_owner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_req <= i_req.payload;
        end
        if (adv) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

endmodule

/* tb/mwf_outcome_checker.sv */
// Checker that predicts each mutex response from the accepted requests and compares it.
module mwf_outcome_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_ready,
    input  mwf_pkg::t_req  i_req,
    input  logic           i_rsp_valid,
    input  logic           i_rsp_ready,
    input  mwf_pkg::t_rsp  i_rsp,
    output int             o_pending,
    output int             o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;
    import mwf_pkg::*;

    logic held;
    t_id  holder;
    t_id  waiters [QDEPTH];
    int   head;
    int   tail;
    int   waiting;
    int   mismatches;
    t_rsp expected_outcomes [$];

    function automatic t_rsp resolve_request(input t_req req);
        t_rsp r;
        r = '0;
        if (req.action == ACT_ACQUIRE) begin
            if (!held) begin
                held = 1'b1;
                holder = req.task_id;
                r.status = ST_GRANTED;
            end else if (holder == req.task_id) begin
                r.status = ST_ALREADY_OWN;
            end else if (waiting >= QDEPTH) begin
                r.status = ST_QUEUE_FULL;
            end else begin
                waiters[tail] = req.task_id;
                tail = (tail + 1) % QDEPTH;
                waiting++;
                r.status = ST_QUEUED;
                r.block_task = 1'b1;
            end
        end else if (held) begin
            if (waiting != 0) begin
                holder = waiters[head];
                head = (head + 1) % QDEPTH;
                waiting--;
                r.wake_valid = 1'b1;
                r.wake_task_id = holder;
            end else begin
                held = 1'b0;
                holder = '0;
            end
        end
        r.owner_valid = held;
        r.owner_id = held ? holder : '0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        bit   bad;
        if (!i_rst_n) begin
            held = 1'b0;
            holder = '0;
            head = 0;
            tail = 0;
            waiting = 0;
            expected_outcomes.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_outcomes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%t: response with no request waiting: %p", $realtime, i_rsp);
                    end
                end else begin
                    want = expected_outcomes.pop_front();
                    bad = (i_rsp.status !== want.status)
                        || (i_rsp.block_task !== want.block_task)
                        || (i_rsp.wake_valid !== want.wake_valid)
                        || (i_rsp.wake_task_id !== want.wake_task_id)
                        || (i_rsp.owner_valid !== want.owner_valid)
                        || (i_rsp.owner_id !== want.owner_id);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%t: response mismatch", $realtime);
                            $display("    expected status %0d block %b wake %b/%h owner %b/%h",
                                     want.status, want.block_task, want.wake_valid,
                                     want.wake_task_id, want.owner_valid, want.owner_id);
                            $display("    actual   status %0d block %b wake %b/%h owner %b/%h",
                                     i_rsp.status, i_rsp.block_task, i_rsp.wake_valid,
                                     i_rsp.wake_task_id, i_rsp.owner_valid, i_rsp.owner_id);
                        end
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                expected_outcomes.push_back(resolve_request(i_req));
            end
        end
        o_pending <= expected_outcomes.size();
        o_mismatches <= mismatches;
    end

endmodule

/* tb/mutex_with_fifo_waiters_test.sv */
// Top of the mutex testbench: clock, reset, request stimulus, response stalls and verdict.
module mutex_with_fifo_waiters_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mwf_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic calm;
    int   pending;
    int   mismatches;

    mwf_req_if req_ch ();
    mwf_rsp_if rsp_ch ();

    mutex_with_fifo_waiters uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    mwf_outcome_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_ch.valid),
        .i_req_ready  (req_ch.ready),
        .i_req        (req_ch.payload),
        .i_rsp_valid  (rsp_ch.valid),
        .i_rsp_ready  (rsp_ch.ready),
        .i_rsp        (rsp_ch.payload),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 12);
    endfunction

    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= !idle_now();
        end
    end

    task automatic send_request(input t_action act, input t_id id);
        t_req r;
        r.action = act;
        r.task_id = id;
        while (idle_now()) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic run_episode(input int count, input int acquire_pct, input bit narrow_ids);
        t_action act;
        t_id     id;
        for (int n = 0; n < count; n++) begin
            act = ($urandom_range(99) < acquire_pct) ? ACT_ACQUIRE : ACT_RELEASE;
            id = narrow_ids ? t_id'($urandom_range(3)) : t_id'($urandom_range(255));
            send_request(act, id);
        end
    endtask

    initial begin
        req_ch.valid <= 1'b0;
        req_ch.payload <= '0;
        i_rst_n <= 1'b0;
        calm <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(ACT_RELEASE, 8'hFF);
        send_request(ACT_ACQUIRE, 8'h00);
        send_request(ACT_ACQUIRE, 8'h00);
        send_request(ACT_ACQUIRE, 8'hFF);
        send_request(ACT_ACQUIRE, 8'hFF);
        send_request(ACT_ACQUIRE, 8'hA5);
        send_request(ACT_ACQUIRE, 8'h5A);
        send_request(ACT_RELEASE, 8'h33);
        send_request(ACT_ACQUIRE, 8'hFF);
        send_request(ACT_RELEASE, 8'h00);
        send_request(ACT_RELEASE, 8'hFF);
        send_request(ACT_RELEASE, 8'h00);
        send_request(ACT_RELEASE, 8'h00);
        send_request(ACT_RELEASE, 8'hFF);
        hold_until_drained();

        for (int rep = 0; rep < 3; rep++) begin
            calm <= (rep == 1);
            run_episode(75, 95, 1'b0);
            hold_until_drained();
            run_episode(70, 5, 1'b0);
            run_episode(25, 50, 1'b1);
            hold_until_drained();
        end
        calm <= 1'b0;

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
